FILE: rtl/core/particle_grid_binning_assert.svh
// Assertion macros of the particle grid binning checker.
`ifndef PARTICLE_GRID_BINNING_ASSERT_SVH
`define PARTICLE_GRID_BINNING_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PGB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/core/pgb_pkg.sv
// Types, constants and helpers of the particle grid binning block.
`default_nettype none
package pgb_pkg;

   localparam int NUM_CELLS        = 4096;
   localparam int BUCKET_DEPTH     = 32;
   localparam int MAX_PARTICLES    = 65536;

   localparam int AXES             = 3;
   localparam int ID_WIDTH         = 16;
   localparam int POS_WIDTH        = 32;
   localparam int OFF_WIDTH        = POS_WIDTH + 1;
   localparam int INV_WIDTH        = 32;
   localparam int PROD_WIDTH       = POS_WIDTH + INV_WIDTH;
   localparam int COUNT_WIDTH      = 7;
   localparam int AXIS_MAX         = 64;
   localparam int COORD_WIDTH      = 6;
   localparam int PLANE_WIDTH      = 13;
   localparam int YMUL_WIDTH       = 13;
   localparam int ZMUL_WIDTH       = 19;
   localparam int SUM_WIDTH        = 20;
   localparam int CELL_INDEX_WIDTH = $clog2(NUM_CELLS);
   localparam int SLOT_WIDTH       = $clog2(BUCKET_DEPTH);
   localparam int FILL_WIDTH       = $clog2(BUCKET_DEPTH + 1);
   localparam int BUCKET_ADDR_WIDTH = CELL_INDEX_WIDTH + SLOT_WIDTH;
   localparam int STATUS_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] CELLS_RESET = COUNT_WIDTH'(16);
   localparam logic [INV_WIDTH-1:0]   INV_RESET   = INV_WIDTH'(65536);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CELLS_X,
      CSR_CELLS_Y,
      CSR_CELLS_Z,
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_INV_CELL_LENGTH
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_STORED,
      STATUS_FULL,
      STATUS_OUTSIDE
   } status_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_FETCH,
      BACK_UPDATE
   } back_state_type;

   // One classified particle on its way from the front to the back.
   typedef struct packed {
      logic [ID_WIDTH-1:0]         particle_id;
      logic [COORD_WIDTH-1:0]      cell_x;
      logic [COORD_WIDTH-1:0]      cell_y;
      logic [COORD_WIDTH-1:0]      cell_z;
      logic [CELL_INDEX_WIDTH-1:0] cell_index;
      logic                        outside;
   } bin_item_type;

   // One result held for the response channel.
   typedef struct packed {
      logic [COORD_WIDTH-1:0]      cell_x;
      logic [COORD_WIDTH-1:0]      cell_y;
      logic [COORD_WIDTH-1:0]      cell_z;
      logic [CELL_INDEX_WIDTH-1:0] cell_index;
      logic [SLOT_WIDTH-1:0]       slot;
      status_type                  status;
   } bin_result_type;

   // Clamp a configured cell count to the largest grid edge.
   function automatic logic [COUNT_WIDTH-1:0] axis_count(input logic [COUNT_WIDTH-1:0] n);
      logic [COUNT_WIDTH-1:0] r;
      r = (n > COUNT_WIDTH'(AXIS_MAX)) ? COUNT_WIDTH'(AXIS_MAX) : n;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pgb_if.sv
// Handshake channel interfaces of the particle grid binning block.
`default_nettype none

// Particle request channel.
interface pgb_req_if;
   import pgb_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [ID_WIDTH-1:0]         particle_id;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic signed [POS_WIDTH-1:0] pos_z;
   modport source (output valid, particle_id, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, particle_id, pos_x, pos_y, pos_z, output ready);
endinterface

// Binning result channel.
interface pgb_rsp_if;
   import pgb_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [COORD_WIDTH-1:0]      cell_x;
   logic [COORD_WIDTH-1:0]      cell_y;
   logic [COORD_WIDTH-1:0]      cell_z;
   logic [CELL_INDEX_WIDTH-1:0] cell_index;
   logic [SLOT_WIDTH-1:0]       slot;
   logic [STATUS_WIDTH-1:0]     status;
   modport source (output valid, cell_x, cell_y, cell_z, cell_index, slot, status,
                   input ready);
   modport sink   (input valid, cell_x, cell_y, cell_z, cell_index, slot, status,
                   output ready);
endinterface

// Register write channel.
interface pgb_csr_if;
   import pgb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pgb_front.sv
// Front end: configuration registers and the three-stage cell classifier.
`default_nettype none
module pgb_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 hold,
   pgb_req_if.sink                   req,
   pgb_csr_if.sink                   csr,
   output pgb_pkg::bin_item_type     push_item,
   output logic                      push_valid,
   input  wire logic                 push_ready
);
   import pgb_pkg::*;

   // Configuration
   logic [COUNT_WIDTH-1:0]      cells_ff  [AXES];
   logic signed [POS_WIDTH-1:0] origin_ff [AXES];
   logic [INV_WIDTH-1:0]        inv_ff;

   logic signed [POS_WIDTH-1:0] pos_w     [AXES];
   logic [COUNT_WIDTH-1:0]      n_w       [AXES];

   // Stage 1: offsets
   logic                        v1_ff, v1_in;
   logic [ID_WIDTH-1:0]         id1_ff;
   logic signed [OFF_WIDTH-1:0] off1_ff   [AXES];
   logic signed [OFF_WIDTH-1:0] off1_in   [AXES];
   logic [PLANE_WIDTH-1:0]      nxny1_ff, nxny1_in;

   // Stage 2: scaled coordinates
   logic                        v2_ff, v2_in;
   logic [ID_WIDTH-1:0]         id2_ff;
   logic                        neg2_ff   [AXES];
   logic [POS_WIDTH-1:0]        hi2_ff    [AXES];
   logic [PROD_WIDTH-1:0]       prod2_w   [AXES];
   logic [PLANE_WIDTH-1:0]      nxny2_ff;

   // Stage 3: range check and index terms
   logic                        v3_ff, v3_in;
   logic [ID_WIDTH-1:0]         id3_ff;
   logic                        ok3_ff, ok3_in;
   logic [COORD_WIDTH-1:0]      c3_ff     [AXES];
   logic [COORD_WIDTH-1:0]      c3_in     [AXES];
   logic [YMUL_WIDTH-1:0]       ymul3_ff, ymul3_in;
   logic [ZMUL_WIDTH-1:0]       zmul3_ff, zmul3_in;
   logic                        inr_w     [AXES];

   logic                        adv1, adv2, adv3;
   logic                        req_fire;
   logic [SUM_WIDTH-1:0]        sum_w;
   logic                        outside_w;

   assign csr.ready = 1'b1;

   // Take register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            cells_ff[a]  <= CELLS_RESET;
            origin_ff[a] <= '0;
         end
         inv_ff <= INV_RESET;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_CELLS_X:         cells_ff[0]  <= csr.data[COUNT_WIDTH-1:0];
            CSR_CELLS_Y:         cells_ff[1]  <= csr.data[COUNT_WIDTH-1:0];
            CSR_CELLS_Z:         cells_ff[2]  <= csr.data[COUNT_WIDTH-1:0];
            CSR_ORIGIN_X:        origin_ff[0] <= csr.data;
            CSR_ORIGIN_Y:        origin_ff[1] <= csr.data;
            CSR_ORIGIN_Z:        origin_ff[2] <= csr.data;
            CSR_INV_CELL_LENGTH: inv_ff       <= csr.data;
            default: ;
         endcase
      end
   end

   // Advance a stage when the one after it is empty or moving
   assign adv3       = !v3_ff || push_ready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req.ready  = adv1 && !hold;
   assign req_fire   = req.valid && req.ready;
   assign push_valid = v3_ff;

   always_comb begin
      pos_w[0] = req.pos_x;
      pos_w[1] = req.pos_y;
      pos_w[2] = req.pos_z;
      for (int a = 0; a < AXES; a++) begin
         n_w[a]     = axis_count(cells_ff[a]);
         off1_in[a] = {pos_w[a][POS_WIDTH-1], pos_w[a]}
                    - {origin_ff[a][POS_WIDTH-1], origin_ff[a]};
         prod2_w[a] = PROD_WIDTH'(off1_ff[a][POS_WIDTH-1:0]) * PROD_WIDTH'(inv_ff);
         inr_w[a]   = !neg2_ff[a] && (hi2_ff[a] < POS_WIDTH'(n_w[a]));
         c3_in[a]   = hi2_ff[a][COORD_WIDTH-1:0];
      end
      nxny1_in = PLANE_WIDTH'(n_w[0]) * PLANE_WIDTH'(n_w[1]);
      ok3_in   = inr_w[0] && inr_w[1] && inr_w[2];
      ymul3_in = YMUL_WIDTH'(c3_in[1]) * YMUL_WIDTH'(n_w[0]);
      zmul3_in = ZMUL_WIDTH'(c3_in[2]) * ZMUL_WIDTH'(nxny2_ff);
      v1_in    = adv1 ? req_fire : v1_ff;
      v2_in    = adv2 ? v1_ff : v2_ff;
      v3_in    = adv3 ? v2_ff : v3_ff;
   end

   // Hold stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Move stage payloads
   always_ff @(posedge clock) begin
      if (adv1) begin
         id1_ff   <= req.particle_id;
         off1_ff  <= off1_in;
         nxny1_ff <= nxny1_in;
      end
      if (adv2) begin
         id2_ff   <= id1_ff;
         nxny2_ff <= nxny1_ff;
         for (int a = 0; a < AXES; a++) begin
            neg2_ff[a] <= off1_ff[a][OFF_WIDTH-1];
            hi2_ff[a]  <= prod2_w[a][PROD_WIDTH-1:POS_WIDTH];
         end
      end
      if (adv3) begin
         id3_ff   <= id2_ff;
         ok3_ff   <= ok3_in;
         c3_ff    <= c3_in;
         ymul3_ff <= ymul3_in;
         zmul3_ff <= zmul3_in;
      end
   end

   // Form the linear index and zero the fields of an outside particle
   always_comb begin
      sum_w     = SUM_WIDTH'(c3_ff[0]) + SUM_WIDTH'(ymul3_ff) + SUM_WIDTH'(zmul3_ff);
      outside_w = !ok3_ff || (sum_w >= SUM_WIDTH'(NUM_CELLS));
      push_item.particle_id = id3_ff;
      push_item.outside     = outside_w;
      push_item.cell_x      = outside_w ? '0 : c3_ff[0];
      push_item.cell_y      = outside_w ? '0 : c3_ff[1];
      push_item.cell_z      = outside_w ? '0 : c3_ff[2];
      push_item.cell_index  = outside_w ? '0 : sum_w[CELL_INDEX_WIDTH-1:0];
   end

endmodule
`default_nettype wire

FILE: rtl/core/pgb_queue.sv
// Short first-in first-out queue between the classifier and the bucket writer.
`default_nettype none
module pgb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire pgb_pkg::bin_item_type push_item,
   output logic                       push_ready,
   output logic                       pop_valid,
   output pgb_pkg::bin_item_type      pop_item,
   input  wire logic                  pop_ready
);
   import pgb_pkg::*;

   bin_item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/pgb_back.sv
// Back end: per-cell fill counts, bucket store and the response register.
`default_nettype none
module pgb_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   input  wire pgb_pkg::bin_item_type pop_item,
   output logic                       pop_ready,
   output logic                       clear_busy,
   pgb_rsp_if.source                  rsp
);
   import pgb_pkg::*;

   logic [FILL_WIDTH-1:0]       fill_mem   [NUM_CELLS];
   logic [ID_WIDTH-1:0]         bucket_mem [NUM_CELLS * BUCKET_DEPTH];

   back_state_type              state_ff, state_in;
   logic [CELL_INDEX_WIDTH-1:0] clr_addr_ff, clr_addr_in;
   bin_item_type                work_ff;
   logic [FILL_WIDTH-1:0]       fill_rd_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   bin_result_type              rsp_item_ff, rsp_item_in;

   logic                        do_pop;
   logic                        out_free;
   logic                        do_update;
   logic                        do_store;
   logic                        bucket_full;
   logic                        clear_last;
   logic [BUCKET_ADDR_WIDTH-1:0] bucket_addr;

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign clear_last  = (clr_addr_ff == CELL_INDEX_WIDTH'(NUM_CELLS - 1));
   assign bucket_full = (fill_rd_ff >= FILL_WIDTH'(BUCKET_DEPTH));
   assign bucket_addr = {work_ff.cell_index, fill_rd_ff[SLOT_WIDTH-1:0]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_CLEAR:  if (clear_last) state_in = BACK_FETCH;
         BACK_FETCH:  if (pop_valid) state_in = BACK_UPDATE;
         BACK_UPDATE: if (out_free) state_in = BACK_FETCH;
         default:     state_in = BACK_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      clear_busy = 1'b0;
      pop_ready  = 1'b0;
      do_update  = 1'b0;
      case (state_ff)
         BACK_CLEAR:  clear_busy = 1'b1;
         BACK_FETCH:  pop_ready  = 1'b1;
         BACK_UPDATE: do_update  = out_free;
         default: ;
      endcase
   end

   assign do_pop   = pop_valid && pop_ready;
   assign do_store = do_update && !work_ff.outside && !bucket_full;

   // Build the result of the particle in work
   always_comb begin
      rsp_item_in.cell_x     = work_ff.cell_x;
      rsp_item_in.cell_y     = work_ff.cell_y;
      rsp_item_in.cell_z     = work_ff.cell_z;
      rsp_item_in.cell_index = work_ff.cell_index;
      rsp_item_in.slot       = '0;
      if (work_ff.outside) begin
         rsp_item_in.status = STATUS_OUTSIDE;
      end else if (bucket_full) begin
         rsp_item_in.status = STATUS_FULL;
      end else begin
         rsp_item_in.status = STATUS_STORED;
         rsp_item_in.slot   = fill_rd_ff[SLOT_WIDTH-1:0];
      end
      clr_addr_in  = clear_busy ? clr_addr_ff + 1'b1 : clr_addr_ff;
      rsp_valid_in = do_update ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Latch the popped particle and the result
   always_ff @(posedge clock) begin
      if (do_pop) begin
         work_ff <= pop_item;
      end
      if (do_update) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Fill count memory: clear sweep, read on pop, write back on store
   always_ff @(posedge clock) begin
      if (clear_busy) begin
         fill_mem[clr_addr_ff] <= '0;
      end else if (do_store) begin
         fill_mem[work_ff.cell_index] <= fill_rd_ff + 1'b1;
      end
      if (do_pop) begin
         fill_rd_ff <= fill_mem[pop_item.cell_index];
      end
   end

   // Bucket store: append the particle id
   always_ff @(posedge clock) begin
      if (do_store) begin
         bucket_mem[bucket_addr] <= work_ff.particle_id;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cell_x     = rsp_item_ff.cell_x;
   assign rsp.cell_y     = rsp_item_ff.cell_y;
   assign rsp.cell_z     = rsp_item_ff.cell_z;
   assign rsp.cell_index = rsp_item_ff.cell_index;
   assign rsp.slot       = rsp_item_ff.slot;
   assign rsp.status     = rsp_item_ff.status;

endmodule
`default_nettype wire

FILE: rtl/core/particle_grid_binning.sv
// Top level of the particle grid binning block.
// Bins particles into a uniform 3D grid and appends the id of each particle inside
// the grid to its cell's bucket while the bucket has room, one result per particle,
// in order. After reset the block runs a clearing pass over the fill count memory,
// one cell a cycle, with req_bus.ready low; register writes are taken at any time
// and csr_bus.ready is always high. The front classifier is a three-stage pipeline
// (offset, 32x32 scale per axis, range check and index terms) that takes one
// particle a cycle into a four-entry queue while the queue has room. The back end
// takes one particle at a time: it reads the cell's count from the fill count
// memory as it pops the particle, then, once the response register is free, writes
// the incremented count back for a stored particle and loads the response register.
`default_nettype none
module particle_grid_binning (
   input  wire logic clock,
   input  wire logic reset,
   pgb_req_if.sink   req_bus,
   pgb_rsp_if.source rsp_bus,
   pgb_csr_if.sink   csr_bus
);
   import pgb_pkg::*;

   bin_item_type push_item;
   logic         push_valid;
   logic         push_ready;
   bin_item_type pop_item;
   logic         pop_valid;
   logic         pop_ready;
   logic         clear_busy;

   pgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clear_busy),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   pgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   pgb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .clear_busy (clear_busy),
      .rsp        (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: rtl/core/pgb_checker.sv
// Port-level assertions of the particle grid binning block and their bind.
`default_nettype none
`include "particle_grid_binning_assert.svh"
module pgb_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [pgb_pkg::COORD_WIDTH-1:0]       rsp_cell_x,
   input wire logic [pgb_pkg::COORD_WIDTH-1:0]       rsp_cell_y,
   input wire logic [pgb_pkg::COORD_WIDTH-1:0]       rsp_cell_z,
   input wire logic [pgb_pkg::CELL_INDEX_WIDTH-1:0]  rsp_cell_index,
   input wire logic [pgb_pkg::SLOT_WIDTH-1:0]        rsp_slot,
   input wire logic [pgb_pkg::STATUS_WIDTH-1:0]      rsp_status
);
   import pgb_pkg::*;

   // A stalled response stays valid and holds its cell index, slot and status
   `PGB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_index) && $stable(rsp_slot) && $stable(rsp_status), "stalled response changed")

   // An outside particle reports all-zero cell fields
   `PGB_ASSERT(a_outside_zero, rsp_valid && (rsp_status == STATUS_OUTSIDE) |-> (rsp_cell_x == '0) && (rsp_cell_y == '0) && (rsp_cell_z == '0) && (rsp_cell_index == '0) && (rsp_slot == '0), "outside result has nonzero fields")

   // A full bucket reports slot zero
   `PGB_ASSERT(a_full_slot, rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_slot == '0), "full result has nonzero slot")

   // No request is taken while the clearing pass starts
   `PGB_ASSERT_ALWAYS(a_clear_blocks, $past(reset) |-> !req_ready, "request ready during clearing pass")

endmodule

bind particle_grid_binning pgb_checker u_pgb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_cell_x     (rsp_bus.cell_x),
   .rsp_cell_y     (rsp_bus.cell_y),
   .rsp_cell_z     (rsp_bus.cell_z),
   .rsp_cell_index (rsp_bus.cell_index),
   .rsp_slot       (rsp_bus.slot),
   .rsp_status     (rsp_bus.status)
);
`default_nettype wire
